// ===== rtl/core/pbc_pkg.sv =====
// shared types, constants and round functions of the present block cipher
package pbc_pkg;

	localparam int ROUNDS = 31;
	localparam int NKEYS  = 32;
	localparam int KA_W   = $clog2(NKEYS);

	localparam logic [1:0] REG_KEY_MODE  = 2'd0;
	localparam logic [1:0] REG_KEY_UPPER = 2'd1;
	localparam logic [1:0] REG_KEY_LOWER = 2'd2;

	localparam logic [3:0] SB [16] = '{
		4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
		4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
	};
	localparam logic [3:0] SB_INV [16] = '{
		4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
		4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
	};

	typedef enum logic [2:0] {
		ST_KLOAD,
		ST_KSCHED,
		ST_IDLE,
		ST_ROUND,
		ST_FINAL
	} state_t;

	function automatic logic [63:0] sub_fwd(input logic [63:0] x);
		logic [63:0] r;
		for (int j = 0; j < 16; j++) begin
			r[4*j +: 4] = SB[x[4*j +: 4]];
		end
		return r;
	endfunction

	function automatic logic [63:0] sub_inv(input logic [63:0] x);
		logic [63:0] r;
		for (int j = 0; j < 16; j++) begin
			r[4*j +: 4] = SB_INV[x[4*j +: 4]];
		end
		return r;
	endfunction

	// bit j moves to 16*j mod 63, bit 63 stays
	function automatic logic [63:0] perm_fwd(input logic [63:0] x);
		logic [63:0] r;
		for (int j = 0; j < 63; j++) begin
			r[(16 * j) % 63] = x[j];
		end
		r[63] = x[63];
		return r;
	endfunction

	// inverse: bit j moves to 4*j mod 63
	function automatic logic [63:0] perm_inv(input logic [63:0] x);
		logic [63:0] r;
		for (int j = 0; j < 63; j++) begin
			r[(4 * j) % 63] = x[j];
		end
		r[63] = x[63];
		return r;
	endfunction

	// one cipher round after the key xor
	function automatic logic [63:0] round_step(input logic [63:0] x, input logic dec);
		logic [63:0] r;
		if (dec) begin
			r = sub_inv(perm_inv(x));
		end else begin
			r = perm_fwd(sub_fwd(x));
		end
		return r;
	endfunction

	// one key schedule step on the 128-bit key state
	function automatic logic [127:0] key_step(input logic [127:0] k, input logic mode,
		input logic [5:0] c);
		logic [127:0] r;
		logic [79:0]  s;
		r = '0;
		if (mode) begin
			r = {k[66:0], k[127:67]};
			r[127:124] = SB[r[127:124]];
			r[123:120] = SB[r[123:120]];
			r[67:62] = r[67:62] ^ c;
		end else begin
			s = {k[18:0], k[79:19]};
			s[79:76] = SB[s[79:76]];
			s[20:15] = s[20:15] ^ c;
			r = {48'd0, s};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/present_block_cipher_top.sv =====
// present block cipher core: key schedule sequencer and round-iterative datapath
// an accepted item runs 31 rounds in ST_ROUND, then the final key xor in ST_FINAL
// a new item is taken only in ST_IDLE, after the last result is loaded; output stall delays that
// key schedule: after reset or any key register write, block stalls in ST_KLOAD, then ST_KSCHED
// reset: asynchronous active low, key registers clear to an all-zero 80-bit key
// round key memory has no reset, it is always refilled by the schedule pass
module present_block_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [63:0] block_in,
	// result item channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_out
);

	localparam logic [pbc_pkg::KA_W-1:0] LAST_KEY  = pbc_pkg::KA_W'(pbc_pkg::NKEYS - 1);
	localparam logic [pbc_pkg::KA_W-1:0] ROUNDS_A  = pbc_pkg::KA_W'(pbc_pkg::ROUNDS);
	localparam logic [pbc_pkg::KA_W-1:0] LAST_RND  = pbc_pkg::KA_W'(pbc_pkg::ROUNDS - 1);

	pbc_pkg::state_t state_q, state_d;

	// configuration registers
	logic         key_mode_q;
	logic [63:0]  key_upper_q;
	logic [63:0]  key_lower_q;
	logic         cfg_hit;

	// key schedule state
	logic [127:0] kst_q;
	logic [pbc_pkg::KA_W-1:0] kcnt_q;
	logic [63:0]  rk_wdata;

	// round key memory, one write port and one registered read port
	logic [63:0]  rk_mem [pbc_pkg::NKEYS];
	logic [63:0]  rk_q;
	logic         rd_en;
	logic [pbc_pkg::KA_W-1:0] rd_addr;

	// datapath
	logic [63:0]  x_q;
	logic         dec_q;
	logic [pbc_pkg::KA_W-1:0] rcnt_q;
	logic [pbc_pkg::KA_W-1:0] rcnt_nxt;
	logic         out_valid_q;
	logic [63:0]  block_out_q;

	// sequencer controls
	logic         accept;
	logic         klod;
	logic         kwr;
	logic         rnd;
	logic         out_load;

	// a write to one of the three key registers restarts the schedule
	assign cfg_hit = cfg_wr_en && (cfg_index inside {pbc_pkg::REG_KEY_MODE,
		pbc_pkg::REG_KEY_UPPER, pbc_pkg::REG_KEY_LOWER});

	assign in_stall  = (state_q != pbc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign block_out = block_out_q;

	// current round key taken from the top of the key state
	assign rk_wdata = key_mode_q ? kst_q[127:64] : kst_q[79:16];

	assign rcnt_nxt = rcnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbc_pkg::ST_KLOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		klod     = 1'b0;
		kwr      = 1'b0;
		rnd      = 1'b0;
		out_load = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		case (state_q)
			pbc_pkg::ST_KLOAD: begin
				klod    = 1'b1;
				state_d = pbc_pkg::ST_KSCHED;
			end
			pbc_pkg::ST_KSCHED: begin
				kwr = 1'b1;
				if (kcnt_q == LAST_KEY) begin
					state_d = pbc_pkg::ST_IDLE;
				end
			end
			pbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					accept  = 1'b1;
					rd_en   = 1'b1;
					// first key: 0 for encryption, the last round key for decryption
					rd_addr = req_type ? ROUNDS_A : '0;
					state_d = pbc_pkg::ST_ROUND;
				end
			end
			pbc_pkg::ST_ROUND: begin
				rnd     = 1'b1;
				rd_en   = 1'b1;
				// decryption walks the keys downward
				rd_addr = dec_q ? (ROUNDS_A - rcnt_nxt) : rcnt_nxt;
				if (rcnt_q == LAST_RND) begin
					state_d = pbc_pkg::ST_FINAL;
				end
			end
			pbc_pkg::ST_FINAL: begin
				// wait for the output register to be free
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = pbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbc_pkg::ST_KLOAD;
			end
		endcase
		if (cfg_hit) begin
			state_d = pbc_pkg::ST_KLOAD;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q  <= 1'b0;
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pbc_pkg::REG_KEY_MODE:  key_mode_q  <= cfg_data[0];
				pbc_pkg::REG_KEY_UPPER: key_upper_q <= cfg_data;
				pbc_pkg::REG_KEY_LOWER: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// schedule counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q <= '0;
		end else if (klod) begin
			kcnt_q <= '0;
		end else if (kwr) begin
			kcnt_q <= kcnt_q + 1'b1;
		end
	end

	// key state, one schedule step per cycle
	always_ff @(posedge clk) begin
		if (klod) begin
			kst_q <= key_mode_q ? {key_upper_q, key_lower_q}
				: {48'd0, key_upper_q[15:0], key_lower_q};
		end else if (kwr) begin
			kst_q <= pbc_pkg::key_step(kst_q, key_mode_q, {1'b0, kcnt_q} + 6'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (kwr) begin
			rk_mem[kcnt_q] <= rk_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rk_q <= rk_mem[rd_addr];
		end
	end

	// round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (accept) begin
			rcnt_q <= '0;
		end else if (rnd) begin
			rcnt_q <= rcnt_nxt;
		end
	end

	// shared round unit: key xor, then s-box and permutation layers (inverse permutation first for decryption)
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= block_in;
			dec_q <= req_type;
		end else if (rnd) begin
			x_q <= pbc_pkg::round_step(x_q ^ rk_q, dec_q);
		end
	end

	// output register, final key xor on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			block_out_q <= x_q ^ rk_q;
		end
	end

endmodule

// ===== rtl/core/present_block_cipher_checker.sv =====
// port-level checker for the present block cipher top, with its bind
module pbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [1:0]  cfg_index,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] block_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_out))
		else $error("stalled result changed");

	// an accepted item keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block ready right after accepting an item");

	// a key write starts the schedule pass
	a_busy_after_key: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && ((cfg_index == pbc_pkg::REG_KEY_MODE) ||
		(cfg_index == pbc_pkg::REG_KEY_UPPER) || (cfg_index == pbc_pkg::REG_KEY_LOWER))
		|=> in_stall)
		else $error("block ready right after a key write");

	// a new result only comes out of a busy block
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");

endmodule

bind present_block_cipher_top pbc_checker u_pbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_wr_en (cfg_wr_en),
	.cfg_index (cfg_index),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.block_out (block_out)
);

// ===== sim/pbc_scoreboard.sv =====
// scoreboard package: block cipher predictor and queue of expected result blocks
package pbc_scoreboard_pkg;

	import pbc_pkg::*;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_e;

	localparam int CIPHER_ROUNDS = 31;

	localparam logic [3:0] SBOX [16] = '{
		4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
		4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
	};
	localparam logic [3:0] SBOX_REV [16] = '{
		4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
		4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
	};

	class cipher_scoreboard;
		logic        wide_key;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [63:0] round_key [32];
		logic [63:0] expected_blocks [$];
		int          failures;

		function new();
			wide_key = 1'b0;
			key_hi   = '0;
			key_lo   = '0;
			failures = 0;
			expand_key();
		endfunction

		// standard schedule: rotate left 61, s-box on the top nibble(s), xor counter
		function void expand_key();
			logic [127:0] k;
			logic [79:0]  s;
			k = {key_hi, key_lo};
			s = {key_hi[15:0], key_lo};
			for (int i = 0; i < 32; i++) begin
				if (wide_key) begin
					round_key[i] = k[127:64];
					k = {k[66:0], k[127:67]};
					k[127:124] = SBOX[k[127:124]];
					k[123:120] = SBOX[k[123:120]];
					k = k ^ (128'(i + 1) << 62);
				end else begin
					round_key[i] = s[79:16];
					s = {s[18:0], s[79:19]};
					s[79:76] = SBOX[s[79:76]];
					s = s ^ (80'(i + 1) << 15);
				end
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				REG_KEY_MODE: wide_key = data[0];
				REG_KEY_UPPER: key_hi = data;
				REG_KEY_LOWER: key_lo = data;
				default: return;
			endcase
			expand_key();
		endfunction

		function logic [63:0] crypt(op_e op, logic [63:0] x);
			logic [63:0] t;
			for (int r = 0; r < CIPHER_ROUNDS; r++) begin
				if (op == OP_ENCRYPT) begin
					x = x ^ round_key[r];
					for (int j = 0; j < 16; j++) t[4*j +: 4] = SBOX[x[4*j +: 4]];
					for (int b = 0; b < 63; b++) x[(16 * b) % 63] = t[b];
					x[63] = t[63];
				end else begin
					x = x ^ round_key[CIPHER_ROUNDS - r];
					for (int b = 0; b < 63; b++) t[(4 * b) % 63] = x[b];
					t[63] = x[63];
					for (int j = 0; j < 16; j++) x[4*j +: 4] = SBOX_REV[t[4*j +: 4]];
				end
			end
			return x ^ ((op == OP_ENCRYPT) ? round_key[CIPHER_ROUNDS] : round_key[0]);
		endfunction

		function void note_request(op_e op, logic [63:0] blk);
			expected_blocks.push_back(crypt(op, blk));
		endfunction

		function void check_block(logic [63:0] actual);
			logic [63:0] want;
			if (expected_blocks.size() == 0) begin
				$error("block_out: expected none, actual %h", actual);
				failures++;
				return;
			end
			want = expected_blocks.pop_front();
			if (actual !== want) begin
				$error("block_out: expected %h, actual %h", want, actual);
				failures++;
			end
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction
	endclass

endpackage

// ===== sim/tb_top.sv =====
// testbench top: drives the present block cipher core and checks every result block
module tb_top;

	import pbc_pkg::*;
	import pbc_scoreboard_pkg::*;

	// generous bound on the whole run, far above the slowest legal run
	localparam int CYCLE_LIMIT      = 400000;
	// tail after the last result: one full item latency plus margin
	localparam int DRAIN_CYCLES     = 40;
	localparam int RANDOM_PER_PHASE = 55;
	// index 3 has no register behind it, writes there must change nothing
	localparam logic [1:0] REG_SPARE = 2'd3;

	// corner blocks for the directed part
	localparam logic [63:0] EDGE_BLOCKS [6] = '{
		64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
		64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
		64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_KEY_MODE;
	logic [63:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        req_type  = OP_ENCRYPT;
	logic [63:0] block_in  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] block_out;

	// idle rates in percent, changed per phase
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int cycle_count   = 0;

	cipher_scoreboard blocks;

	present_block_cipher_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.block_in  (block_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.block_out (block_out)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stall per cycle at the current rate
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// monitor: all signals are sampled at the edge, before any update of this step
	always @(posedge clk) begin
		if (arst_n) begin
			// register writes refresh the predicted round keys right away
			if (cfg_wr_en)
				blocks.write_reg(cfg_index, cfg_data);
			if (in_valid && in_stall === 1'b0)
				blocks.note_request(op_e'(req_type), block_in);
			if (out_valid === 1'b1 && !out_stall)
				blocks.check_block(block_out);
		end
	end

	// offer one item after a random idle gap and hold it until taken
	task automatic send_block(input op_e op, input logic [63:0] blk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		block_in <= blk;
		do @(posedge clk); while (!(in_valid && in_stall === 1'b0));
	endtask

	// drop valid, let the monitor see the last item, then wait for every result
	task automatic finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (blocks.pending() != 0) @(posedge clk);
	endtask

	// back-to-back writes of all three key registers, optionally one to the spare index
	task automatic load_key(input logic wide, input logic [63:0] hi, input logic [63:0] lo,
		input bit poke_spare);
		logic [63:0] mode_word;
		// junk above bit 0 of the mode word must be ignored
		mode_word = {$urandom, $urandom};
		mode_word[0] = wide;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_KEY_MODE;
		cfg_data  <= mode_word;
		@(posedge clk);
		cfg_index <= REG_KEY_UPPER;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_KEY_LOWER;
		cfg_data  <= lo;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data  <= {$urandom, $urandom};
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// random blocks, both operations, with all-zero and all-one blocks mixed in
	task automatic random_phase(input int send_pct, input int recv_pct);
		logic [63:0] blk;
		int          pick;
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
		repeat (RANDOM_PER_PHASE) begin
			pick = $urandom_range(0, 15);
			blk  = {$urandom, $urandom};
			if (pick == 0)
				blk = '0;
			else if (pick == 1)
				blk = '1;
			send_block(op_e'($urandom_range(0, 1)), blk);
		end
		finish_phase();
	endtask

	initial begin
		blocks = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset key (all zero, 80-bit), no idling;
		// the block stalls through its key schedule pass first
		foreach (EDGE_BLOCKS[i]) begin
			send_block(OP_ENCRYPT, EDGE_BLOCKS[i]);
			send_block(OP_DECRYPT, EDGE_BLOCKS[i]);
		end
		// round trips: decrypt a known ciphertext, encrypt a known plaintext
		send_block(OP_DECRYPT, blocks.crypt(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF));
		send_block(OP_ENCRYPT, blocks.crypt(OP_DECRYPT, 64'hFEDC_BA98_7654_3210));
		finish_phase();

		// 80-bit key with junk in the unused upper bits of key_upper
		load_key(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		random_phase(63, 0);
		// 80-bit all-ones key
		load_key(1'b0, '1, '1, 1'b0);
		random_phase(0, 63);
		// 128-bit all-zero key
		load_key(1'b1, '0, '0, 1'b0);
		random_phase(10, 10);
		// 128-bit all-ones key, plus a write to the spare index
		load_key(1'b1, '1, '1, 1'b1);
		random_phase(0, 0);
		load_key(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		random_phase(63, 0);
		load_key(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
		random_phase(0, 63);
		load_key(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		random_phase(10, 10);
		// back to the reset key, this time by writes
		load_key(1'b0, '0, '0, 1'b0);
		random_phase(0, 0);

		// quiet tail so a stray extra result would still be caught
		stall_pct <= 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (blocks.failures == 0 && blocks.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pbc_pkg.sv
rtl/core/present_block_cipher_top.sv
rtl/core/present_block_cipher_checker.sv
sim/pbc_scoreboard.sv
sim/tb_top.sv
